// ===== rtl/bmp_sd_pkg.sv =====
package bmp_sd_pkg;

    localparam int MAX_DIMENSION = 8192;
    localparam int DIM_LIMIT     = (MAX_DIMENSION < 8192) ? MAX_DIMENSION : 8192;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIG  = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd2;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] column;
        logic [12:0] row;
        logic [13:0] image_width;
        logic [13:0] image_height;
        logic [1:0]  status;
        logic        last;
    } t_result;

endpackage

// ===== rtl/bmp_sd_core.sv =====
module bmp_sd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic                 i_sof,
    output logic                 o_res_valid,
    output bmp_sd_pkg::t_result  o_res
);
    import bmp_sd_pkg::*;

    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_FILEHDR = 3'd1;
    localparam logic [2:0] PH_HDRSIZE = 3'd2;
    localparam logic [2:0] PH_BODY    = 3'd3;
    localparam logic [2:0] PH_PIXELS  = 3'd4;

    localparam logic [1:0] HK_NONE = 2'd0;
    localparam logic [1:0] HK_12   = 2'd1;
    localparam logic [1:0] HK_16   = 2'd2;
    localparam logic [1:0] HK_40   = 2'd3;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_T = 8'h54;

    localparam logic [31:0] HDR_SIZE_12 = 32'd12;
    localparam logic [31:0] HDR_SIZE_16 = 32'd16;
    localparam logic [31:0] HDR_SIZE_40 = 32'd40;
    localparam logic [5:0]  FILEHDR_END = 6'd13;
    localparam logic [15:0] DEPTH_24    = 16'd24;

    function automatic logic sig_ok(input logic [7:0] a, input logic [7:0] b);
        return (a == CH_B && b == CH_M) || (a == CH_B && b == CH_A) ||
               (a == CH_C && b == CH_I) || (a == CH_C && b == CH_P) ||
               (a == CH_I && b == CH_C) || (a == CH_P && b == CH_T);
    endfunction

    // zero marks an unusable dimension
    function automatic logic [13:0] check_dim(input logic [31:0] v);
        if (v == 32'd0 || v > 32'(DIM_LIMIT)) begin
            return 14'd0;
        end
        return v[13:0];
    endfunction

    logic [2:0]  r_phase,  n_phase;
    logic [5:0]  r_count,  n_count;
    logic [1:0]  r_hkind,  n_hkind;
    logic [31:0] r_shift,  n_shift;
    logic [13:0] r_width,  n_width;
    logic [13:0] r_height, n_height;
    logic [15:0] r_depth,  n_depth;
    logic [12:0] r_col,    n_col;
    logic [12:0] r_row,    n_row;
    logic [15:0] r_pix,    n_pix;
    logic [1:0]  r_bip,    n_bip;
    logic [1:0]  r_pad,    n_pad;

    always_comb begin
        logic        v_clear;
        logic [5:0]  v_body_len;
        logic [2:0]  v_len;
        logic [1:0]  v_idx;
        logic [1:0]  v_fid;
        logic [31:0] v_shift;
        logic [13:0] v_top;
        logic        v_last;

        n_phase  = r_phase;
        n_count  = r_count;
        n_hkind  = r_hkind;
        n_shift  = r_shift;
        n_width  = r_width;
        n_height = r_height;
        n_depth  = r_depth;
        n_col    = r_col;
        n_row    = r_row;
        n_pix    = r_pix;
        n_bip    = r_bip;
        n_pad    = r_pad;
        o_res_valid = 1'b0;
        o_res    = '0;
        v_clear  = 1'b0;
        v_body_len = 6'd8;
        v_len    = 3'd0;
        v_idx    = 2'd0;
        v_fid    = 2'd0;
        v_shift  = r_shift;
        v_top    = 14'd0;
        v_last   = 1'b0;

        if (i_take && !i_sof) begin
            case (r_phase)
                PH_FILEHDR: begin
                    if (r_count == 6'd1 && !sig_ok(r_shift[7:0], i_byte)) begin
                        v_clear = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind = KIND_ERROR;
                        o_res.status = STATUS_BAD_SIG;
                        o_res.last = 1'b1;
                    end else if (r_count >= FILEHDR_END) begin
                        n_phase = PH_HDRSIZE;
                        n_count = 6'd0;
                        n_shift = 32'd0;
                    end else begin
                        n_count = r_count + 6'd1;
                    end
                end
                PH_HDRSIZE: begin
                    v_shift = r_shift | ({24'd0, i_byte} << {r_count[1:0], 3'b000});
                    n_shift = v_shift;
                    if (r_count[1:0] == 2'd3) begin
                        n_phase = PH_BODY;
                        n_count = 6'd0;
                        n_shift = 32'd0;
                        if (v_shift == HDR_SIZE_12) begin
                            n_hkind = HK_12;
                        end else if (v_shift == HDR_SIZE_16) begin
                            n_hkind = HK_16;
                        end else if (v_shift == HDR_SIZE_40) begin
                            n_hkind = HK_40;
                        end else begin
                            v_clear = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERROR;
                            o_res.status = STATUS_BAD_HDR;
                            o_res.last = 1'b1;
                        end
                    end else begin
                        n_count = r_count + 6'd1;
                    end
                end
                PH_BODY: begin
                    // 16-byte form carries 24 skipped bytes after its fields
                    v_body_len = (r_hkind == HK_40) ? 6'd36 :
                                 (r_hkind == HK_16) ? 6'd32 : 6'd8;
                    if (r_hkind == HK_40) begin
                        if (r_count < 6'd8) begin
                            v_len = 3'd4;
                            v_idx = r_count[1:0];
                            v_fid = {1'b0, r_count[2]};
                        end else if (r_count < 6'd12) begin
                            v_len = 3'd2;
                            v_idx = {1'b0, r_count[0]};
                            v_fid = {1'b1, r_count[1]};
                        end
                    end else if (r_count < 6'd8) begin
                        v_len = 3'd2;
                        v_idx = {1'b0, r_count[0]};
                        v_fid = r_count[2:1];
                    end
                    if (v_len != 3'd0) begin
                        if (v_idx == 2'd0) begin
                            v_shift = {24'd0, i_byte};
                        end else begin
                            v_shift = r_shift | ({24'd0, i_byte} << {v_idx, 3'b000});
                        end
                        n_shift = v_shift;
                        if ({1'b0, v_idx} == v_len - 3'd1) begin
                            case (v_fid)
                                2'd0:    n_width  = check_dim(v_shift);
                                2'd1:    n_height = check_dim(v_shift);
                                2'd3:    n_depth  = v_shift[15:0];
                                default: ;
                            endcase
                        end
                    end
                    if ({1'b0, r_count} + 7'd1 >= {1'b0, v_body_len}) begin
                        if (n_depth != DEPTH_24 || n_width == 14'd0 || n_height == 14'd0) begin
                            v_clear = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_ERROR;
                            o_res.status = STATUS_BAD_SIZE;
                            o_res.last = 1'b1;
                        end else begin
                            n_phase = PH_PIXELS;
                            n_count = 6'd0;
                            n_shift = 32'd0;
                            o_res_valid = 1'b1;
                            o_res.kind = KIND_HEADER;
                            o_res.image_width = n_width;
                            o_res.image_height = n_height;
                        end
                    end else begin
                        n_count = r_count + 6'd1;
                    end
                end
                PH_PIXELS: begin
                    if (r_pad != 2'd0) begin
                        n_pad = r_pad - 2'd1;
                    end else if (r_bip == 2'd0) begin
                        n_pix = {8'd0, i_byte};
                        n_bip = 2'd1;
                    end else if (r_bip == 2'd1) begin
                        n_pix = {i_byte, r_pix[7:0]};
                        n_bip = 2'd2;
                    end else begin
                        n_bip = 2'd0;
                        // rows arrive bottom-up
                        v_top = r_height - 14'd1 - {1'b0, r_row};
                        if ({1'b0, r_col} + 14'd1 >= r_width) begin
                            n_col = 13'd0;
                            n_pad = r_width[1:0];
                            if ({1'b0, r_row} + 14'd1 >= r_height) begin
                                v_last = 1'b1;
                            end else begin
                                n_row = r_row + 13'd1;
                            end
                        end else begin
                            n_col = r_col + 13'd1;
                        end
                        o_res_valid = 1'b1;
                        o_res.kind = KIND_PIXEL;
                        o_res.red = i_byte;
                        o_res.green = r_pix[15:8];
                        o_res.blue = r_pix[7:0];
                        o_res.column = r_col;
                        o_res.row = v_top[12:0];
                        o_res.last = v_last;
                        v_clear = v_last;
                    end
                end
                default: ;
            endcase
        end

        if (v_clear || (i_take && i_sof)) begin
            n_phase  = PH_WAIT;
            n_count  = 6'd0;
            n_hkind  = HK_NONE;
            n_shift  = 32'd0;
            n_width  = 14'd0;
            n_height = 14'd0;
            n_depth  = 16'd0;
            n_col    = 13'd0;
            n_row    = 13'd0;
            n_pix    = 16'd0;
            n_bip    = 2'd0;
            n_pad    = 2'd0;
        end
        if (i_take && i_sof) begin
            n_phase = PH_FILEHDR;
            n_shift = {24'd0, i_byte};
            n_count = 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_count  <= 6'd0;
            r_hkind  <= HK_NONE;
            r_shift  <= 32'd0;
            r_width  <= 14'd0;
            r_height <= 14'd0;
            r_depth  <= 16'd0;
            r_col    <= 13'd0;
            r_row    <= 13'd0;
            r_pix    <= 16'd0;
            r_bip    <= 2'd0;
            r_pad    <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_hkind  <= n_hkind;
            r_shift  <= n_shift;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pix    <= n_pix;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
        end
    end

endmodule

// ===== rtl/bmp_stream_decoder.sv =====
// output: a result is written into the output queue at the edge its byte is
// accepted and shows on the output ports once it reaches the head of the queue
// throughput: one byte per cycle; the two-entry result queue stalls input only when full
// reset: synchronous, active low; parser returns to waiting for a start byte,
// queue is emptied
module bmp_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [12:0] o_column,
    output logic [12:0] o_row,
    output logic [13:0] o_image_width,
    output logic [13:0] o_image_height,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import bmp_sd_pkg::*;

    logic    take;
    logic    res_valid;
    t_result res;
    logic    push;
    logic    pop;
    t_result head;

    t_result    r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_in_stall = (r_count == 2'd2);
    assign take = i_in_valid && !o_in_stall;

    bmp_sd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_data_byte),
        .i_sof       (i_start_of_file),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign push = take && res_valid;
    assign pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign head           = r_queue[r_rd_ptr];
    assign o_out_valid    = (r_count != 2'd0);
    assign o_kind         = head.kind;
    assign o_red          = head.red;
    assign o_green        = head.green;
    assign o_blue         = head.blue;
    assign o_column       = head.column;
    assign o_row          = head.row;
    assign o_image_width  = head.image_width;
    assign o_image_height = head.image_height;
    assign o_status       = head.status;
    assign o_last         = head.last;

    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("result queue count did not drop on pop");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ERROR) |-> (o_last && o_status != STATUS_OK))
        else $error("error result without last or status");

    a_header_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_HEADER) |->
        (o_image_width != 14'd0 && o_image_height != 14'd0 && !o_last))
        else $error("header result with zero dimension");

    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_PIXEL) |->
        (o_status == STATUS_OK && o_image_width == 14'd0 && o_image_height == 14'd0))
        else $error("pixel result carries header or status bits");

endmodule

// ===== test/bmp_stream_decoder_tb.sv =====
`timescale 1ns / 1ps

module bmp_stream_decoder_tb;

    import bmp_sd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 1300;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_PRINTED    = 100;

    localparam logic [31:0] INFO_SIZE_OS2   = 32'd12;
    localparam logic [31:0] INFO_SIZE_SHORT = 32'd16;
    localparam logic [31:0] INFO_SIZE_FULL  = 32'd40;
    localparam logic [15:0] PIXEL_DEPTH     = 16'd24;

    localparam logic [15:0] VALID_SIGS [6] = '{"BM", "BA", "CI", "CP", "IC", "PT"};

    typedef enum logic [2:0] {
        PH_IDLE, PH_FILE_HDR, PH_HDR_SIZE, PH_INFO, PH_PIXELS
    } parse_phase_e;

    typedef enum logic [1:0] {
        INFO_NONE, INFO_OS2, INFO_SHORT, INFO_FULL
    } info_form_e;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE
    } stall_mode_e;

    typedef struct {
        logic [7:0] data;
        logic       sof;
    } t_byte_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_start_of_file = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [12:0] o_column;
    logic [12:0] o_row;
    logic [13:0] o_image_width;
    logic [13:0] o_image_height;
    logic [1:0]  o_status;
    logic        o_last;

    bmp_stream_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_column        (o_column),
        .o_row           (o_row),
        .o_image_width   (o_image_width),
        .o_image_height  (o_image_height),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    t_byte_req pending_bytes[$];
    t_result   expected_results[$];
    int        total_bytes = 0;
    int        accepted_bytes = 0;
    int        results_checked = 0;
    int        mismatch_count = 0;

    // decoder state
    parse_phase_e dec_phase;
    logic [6:0]   dec_count;
    info_form_e   dec_info;
    logic [31:0]  dec_shift;
    logic [13:0]  dec_width;
    logic [13:0]  dec_height;
    logic [15:0]  dec_depth;
    logic [12:0]  dec_col;
    logic [12:0]  dec_row;
    logic [15:0]  dec_pixel;
    logic [1:0]   dec_byte_sel;
    logic [1:0]   dec_pad;

    task automatic clear_parser();
        dec_phase    = PH_IDLE;
        dec_count    = '0;
        dec_info     = INFO_NONE;
        dec_shift    = '0;
        dec_width    = '0;
        dec_height   = '0;
        dec_depth    = '0;
        dec_col      = '0;
        dec_row      = '0;
        dec_pixel    = '0;
        dec_byte_sel = '0;
        dec_pad      = '0;
    endtask

    function automatic bit sig_valid(logic [7:0] first, logic [7:0] second);
        for (int i = 0; i < 6; i++) begin
            if ({first, second} == VALID_SIGS[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // zero marks an unusable dimension
    function automatic logic [13:0] usable_dim(logic [31:0] v, bit signed_form);
        if (signed_form && v[31]) return '0;
        if (v == 0 || v > MAX_DIMENSION || v > 8192) return '0;
        return v[13:0];
    endfunction

    task automatic abort_file(input logic [1:0] code, output t_result r);
        clear_parser();
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = code;
        r.last   = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof,
                               output bit emits, output t_result r);
        int unsigned off;
        int unsigned body_len;
        int unsigned flen;
        int unsigned fidx;
        int unsigned fid;
        emits = 1'b0;
        r = '0;
        if (sof) begin
            clear_parser();
            dec_phase = PH_FILE_HDR;
            dec_shift = {24'd0, b};
            dec_count = 7'd1;
        end else begin
            case (dec_phase)
                PH_FILE_HDR: begin
                    if (dec_count == 7'd1 && !sig_valid(dec_shift[7:0], b)) begin
                        abort_file(STATUS_BAD_SIG, r);
                        emits = 1'b1;
                    end else if (dec_count >= 7'd13) begin
                        dec_phase = PH_HDR_SIZE;
                        dec_count = '0;
                        dec_shift = '0;
                    end else begin
                        dec_count++;
                    end
                end
                PH_HDR_SIZE: begin
                    dec_shift |= 32'(b) << (8 * dec_count[1:0]);
                    if (dec_count[1:0] == 2'd3) begin
                        if (dec_shift == INFO_SIZE_OS2) dec_info = INFO_OS2;
                        else if (dec_shift == INFO_SIZE_SHORT) dec_info = INFO_SHORT;
                        else if (dec_shift == INFO_SIZE_FULL) dec_info = INFO_FULL;
                        else begin
                            abort_file(STATUS_BAD_HDR, r);
                            emits = 1'b1;
                        end
                        if (!emits) begin
                            dec_phase = PH_INFO;
                            dec_count = '0;
                            dec_shift = '0;
                        end
                    end else begin
                        dec_count++;
                    end
                end
                PH_INFO: begin
                    off = dec_count;
                    body_len = (dec_info == INFO_FULL) ? 36 : (dec_info == INFO_SHORT) ? 32 : 8;
                    flen = 0;
                    fidx = 0;
                    fid = 0;
                    // full form: 32-bit width and height, then 16-bit planes and depth
                    if (dec_info == INFO_FULL) begin
                        if (off < 8) begin
                            flen = 4;
                            fidx = off % 4;
                            fid = off / 4;
                        end else if (off < 12) begin
                            flen = 2;
                            fidx = off % 2;
                            fid = 2 + (off - 8) / 2;
                        end
                    end else if (off < 8) begin
                        flen = 2;
                        fidx = off % 2;
                        fid = off / 2;
                    end
                    if (flen != 0) begin
                        if (fidx == 0) dec_shift = {24'd0, b};
                        else dec_shift |= 32'(b) << (8 * fidx);
                        if (fidx == flen - 1) begin
                            if (fid == 0) dec_width = usable_dim(dec_shift, dec_info == INFO_FULL);
                            else if (fid == 1) dec_height = usable_dim(dec_shift, dec_info == INFO_FULL);
                            else if (fid == 3) dec_depth = dec_shift[15:0];
                        end
                    end
                    if (off + 1 >= body_len) begin
                        emits = 1'b1;
                        if (dec_depth != PIXEL_DEPTH || dec_width == 0 || dec_height == 0) begin
                            abort_file(STATUS_BAD_SIZE, r);
                        end else begin
                            dec_phase      = PH_PIXELS;
                            dec_count      = '0;
                            dec_shift      = '0;
                            r.kind         = KIND_HEADER;
                            r.image_width  = dec_width;
                            r.image_height = dec_height;
                        end
                    end else begin
                        dec_count = 7'(off + 1);
                    end
                end
                PH_PIXELS: begin
                    if (dec_pad != 0) begin
                        dec_pad--;
                    end else if (dec_byte_sel == 2'd0) begin
                        dec_pixel = {8'd0, b};
                        dec_byte_sel = 2'd1;
                    end else if (dec_byte_sel == 2'd1) begin
                        dec_pixel[15:8] = b;
                        dec_byte_sel = 2'd2;
                    end else begin
                        // file order is blue, green, red; rows are stored bottom-up
                        r.kind   = KIND_PIXEL;
                        r.red    = b;
                        r.green  = dec_pixel[15:8];
                        r.blue   = dec_pixel[7:0];
                        r.column = dec_col;
                        r.row    = 13'(dec_height - 14'd1 - 14'(dec_row));
                        dec_byte_sel = 2'd0;
                        if (dec_col + 1 >= dec_width) begin
                            dec_col = '0;
                            dec_pad = dec_width[1:0];
                            if (dec_row + 1 >= dec_height) r.last = 1'b1;
                            else dec_row++;
                        end else begin
                            dec_col++;
                        end
                        emits = 1'b1;
                        if (r.last) clear_parser();
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic add_noise(input int count);
        t_byte_req req;
        repeat (count) begin
            req.data = 8'($urandom);
            req.sof = 1'b0;
            pending_bytes.push_back(req);
        end
    endtask

    task automatic add_file(input logic [15:0] sig, input logic [31:0] info_size,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] depth, input int cut_at);
        logic [7:0]  file_bytes[$];
        t_byte_req   req;
        int unsigned img_w;
        int unsigned img_h;
        bit          full_form;
        int          i;
        full_form = (info_size == INFO_SIZE_FULL);
        file_bytes.push_back(sig[15:8]);
        file_bytes.push_back(sig[7:0]);
        // size, reserved and offset words are skipped by the decoder
        repeat (12) file_bytes.push_back(8'($urandom));
        for (i = 0; i < 4; i++) file_bytes.push_back(info_size[8*i +: 8]);
        for (i = 0; i < (full_form ? 4 : 2); i++) file_bytes.push_back(w[8*i +: 8]);
        for (i = 0; i < (full_form ? 4 : 2); i++) file_bytes.push_back(h[8*i +: 8]);
        repeat (2) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(depth[7:0]);
        file_bytes.push_back(depth[15:8]);
        if (info_size != INFO_SIZE_OS2) repeat (24) file_bytes.push_back(8'($urandom));
        img_w = full_form ? w : w[15:0];
        img_h = full_form ? h : h[15:0];
        if (depth == PIXEL_DEPTH && img_w >= 1 && img_w <= 8192 && img_h >= 1 && img_h <= 8192) begin
            repeat (img_h) begin
                repeat (3 * img_w + img_w % 4) file_bytes.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
        if (cut_at >= 1) begin
            while (file_bytes.size() > cut_at) void'(file_bytes.pop_back());
        end
        for (i = 0; i < file_bytes.size(); i++) begin
            req.data = file_bytes[i];
            req.sof = (i == 0);
            pending_bytes.push_back(req);
        end
    endtask

    // mostly small usable sizes, sometimes one the decoder must reject
    function automatic logic [31:0] random_dim(input int typical_max);
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'd8193;
            2: return 32'h0000_FFFF;
            3: return {1'b1, 15'($urandom), 16'($urandom_range(1, 6))};
            4: return 32'h0001_0003;
            default: return 32'($urandom_range(1, typical_max));
        endcase
    endfunction

    task automatic add_random_file();
        logic [15:0] sig;
        logic [31:0] info_size;
        logic [15:0] depth;
        int          pick;
        sig = ($urandom_range(0, 9) == 0) ? 16'($urandom) : VALID_SIGS[$urandom_range(0, 5)];
        pick = $urandom_range(0, 19);
        if (pick < 6) info_size = INFO_SIZE_OS2;
        else if (pick < 12) info_size = INFO_SIZE_SHORT;
        else if (pick < 19) info_size = INFO_SIZE_FULL;
        else info_size = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 64));
        pick = $urandom_range(0, 19);
        if (pick == 0) depth = 16'($urandom);
        else if (pick == 1) depth = 16'h0118;
        else if (pick == 2) depth = 16'd32;
        else depth = PIXEL_DEPTH;
        add_file(sig, info_size, random_dim(9), random_dim(4), depth,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) : -1);
        if ($urandom_range(0, 9) == 0) add_noise($urandom_range(1, 6));
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    // sender: bursts of random length separated by random gaps
    int        burst_left = 0;
    int        gap_left = 0;
    bit        drv_emits;
    t_result   drv_res;
    t_byte_req drv_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            clear_parser();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_data_byte, i_start_of_file, drv_emits, drv_res);
                if (drv_emits) expected_results.push_back(drv_res);
                accepted_bytes++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    drv_req = pending_bytes.pop_front();
                    i_data_byte <= drv_req.data;
                    i_start_of_file <= drv_req.sof;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                                  : $urandom_range(1, 30);
                        gap_left <= $urandom_range(1, 15);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results and stalls in modes of random length
    stall_mode_e stall_mode = STALL_NONE;
    int          stall_span = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    t_result     mon_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request behind it");
                end else begin
                    mon_want = expected_results.pop_front();
                    check_field("kind", o_kind, mon_want.kind);
                    check_field("red", o_red, mon_want.red);
                    check_field("green", o_green, mon_want.green);
                    check_field("blue", o_blue, mon_want.blue);
                    check_field("column", o_column, mon_want.column);
                    check_field("row", o_row, mon_want.row);
                    check_field("image_width", o_image_width, mon_want.image_width);
                    check_field("image_height", o_image_height, mon_want.image_height);
                    check_field("status", o_status, mon_want.status);
                    check_field("last", o_last, mon_want.last);
                end
                results_checked++;
            end
            // one long hold-off so the result queue fills and input backs up
            if (!hold_done && results_checked >= 30) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_span == 0) begin
                    stall_mode <= stall_mode_e'($urandom_range(0, 3));
                    stall_span <= $urandom_range(20, 300);
                end else begin
                    stall_span <= stall_span - 1;
                end
                case (stall_mode)
                    STALL_NONE:   i_out_stall <= 1'b0;
                    STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: i_out_stall <= ~i_out_stall;
                    default:      i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int stop_at;
        // stray byte with no file open
        add_noise(1);
        // bad signature
        add_file("BX", INFO_SIZE_FULL, 32'd2, 32'd2, PIXEL_DEPTH, 3);
        // unsupported header size
        add_file("PT", 32'hFFFF_FFFF, 32'd1, 32'd1, PIXEL_DEPTH, 19);
        // smallest image with trailing bytes
        add_file("BM", INFO_SIZE_OS2, 32'd1, 32'd1, PIXEL_DEPTH, -1);
        // dimension, sign and depth rejects
        add_file("CI", INFO_SIZE_FULL, 32'd8193, 32'd1, PIXEL_DEPTH, -1);
        add_file("CP", INFO_SIZE_FULL, 32'd2, 32'h8000_0002, PIXEL_DEPTH, -1);
        add_file("IC", INFO_SIZE_SHORT, 32'd3, 32'd2, 16'd32, -1);
        add_file("BA", INFO_SIZE_FULL, 32'd0, 32'd2, PIXEL_DEPTH, -1);
        // restart in the middle of the pixel data
        add_file("BA", INFO_SIZE_FULL, 32'd5, 32'd3, PIXEL_DEPTH, 60);
        add_file("BM", INFO_SIZE_SHORT, 32'd6, 32'd2, PIXEL_DEPTH, -1);
        stop_at = pending_bytes.size() + RANDOM_BYTES;
        while (pending_bytes.size() < stop_at) add_random_file();
        // largest usable width and height, cut after the first pixels
        add_file("BM", INFO_SIZE_FULL, 32'd8192, 32'd1, PIXEL_DEPTH, 90);
        add_file("PT", INFO_SIZE_OS2, 32'd1, 32'd8192, PIXEL_DEPTH, 66);
        total_bytes = pending_bytes.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_bytes < total_bytes || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
